@@ sv/rhp_pkg.sv @@
// ----------------------------------------------------------------------------
// RTP header parser package
// Shared types and constants for the RTP header parser.
// ----------------------------------------------------------------------------
package rhp_pkg;

  localparam int unsigned MaxPacketBytes = 2048;
  localparam int unsigned FixedHdrBytes  = 12;
  // Width of the payload start offset: 12 + 60 + 4 + 4 * 65535 fits in 19 bits.
  localparam int unsigned PsW            = 19;
  // Width of a stored packet length; MAX_PACKET_BYTES must not exceed 65535, which the block does not enforce.
  localparam int unsigned LenW           = 16;
  localparam logic [31:0] PackStartCode  = 32'h0000_01BA;
  localparam logic [1:0]  RtpVersion     = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_BAD_VER    = 3'd2,
    ST_CSRC_OVR   = 3'd3,
    ST_EXT_OVR    = 3'd4,
    ST_PAD_OVR    = 3'd5,
    ST_TOO_LONG   = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic        marker;
    logic [6:0]  payload_type;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    logic [31:0] source_id;
    logic [3:0]  csrc_count;
    logic        has_extension;
    logic        has_padding;
    logic [11:0] header_length;
    logic [11:0] payload_length;
    logic        ps_start;
  } out_t;

  // Everything the checking stage needs about one finished packet.
  typedef struct packed {
    logic [7:0]      first_byte;
    logic [7:0]      second_byte;
    logic [15:0]     seq;
    logic [31:0]     stamp;
    logic [31:0]     ssrc;
    logic [31:0]     head;
    logic [PsW-1:0]  hdr;
    logic [PsW:0]    hdr_pad;
    logic [LenW-1:0] len;
    logic            ovf;
  } snap_t;

endpackage

@@ sv/rtp_header_parser.sv @@
// ----------------------------------------------------------------------------
// RTP header parser
// Parses an RTP packet arriving one byte per item and returns one status
// record per packet with the header fields, lengths and a pack start flag.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                                Carries
//  in        input      in_valid_i, in_ready_o, in_data_i      packet byte, last flag
//  out       output     out_valid_o, out_ready_i, out_data_o   status record per packet
//
//  One byte is taken per cycle while in_ready_o is high; the capture registers
//  update on acceptance. The last byte of a packet moves a snapshot into a check
//  stage, and the status record moves from there into the output register once
//  that register is empty or being read. Input stalls only while the snapshot
//  and the output register are both full and the output is not being read.
//  Reset clears the capture state and both valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module rtp_header_parser #(
  parameter int unsigned MAX_PACKET_BYTES = rhp_pkg::MaxPacketBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rhp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rhp_pkg::out_t out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PACKET_BYTES);
  localparam int unsigned PsW = rhp_pkg::PsW;
  localparam logic [PsW-1:0] PsReset = PsW'(rhp_pkg::FixedHdrBytes);

  // Capture state
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      fhb_q, fhb_d;
  logic [7:0]      shb_q, shb_d;
  logic [15:0]     seq_q, seq_d;
  logic [31:0]     stamp_q, stamp_d;
  logic [31:0]     ssrc_q, ssrc_d;
  logic [15:0]     ext_q, ext_d;
  logic [PsW-1:0]  ps_q, ps_d;
  logic [31:0]     head_q, head_d;

  logic            in_acc;
  logic            in_range;
  logic [7:0]      din;
  logic [PsW:0]    pos_x;
  logic [PsW:0]    off;
  logic [6:0]      xo;
  logic [6:0]      xo_d;

  // Snapshot and output stages
  rhp_pkg::snap_t snap_d, snap_q;
  logic           s_valid_q;
  rhp_pkg::out_t  res_d, res_q;
  logic           o_valid_q;
  logic           o_load;

  assign in_acc   = in_valid_i && in_ready_o;
  assign din      = in_data_i.data_byte;
  assign in_range = count_q < MaxCnt;
  assign pos_x    = (PsW + 1)'(count_q);
  assign off      = pos_x - (PsW + 1)'(ps_q);
  assign xo       = 7'(rhp_pkg::FixedHdrBytes) + {1'b0, fhb_q[3:0], 2'b00};

  always_comb begin
    fhb_d   = fhb_q;
    shb_d   = shb_q;
    seq_d   = seq_q;
    stamp_d = stamp_q;
    ssrc_d  = ssrc_q;
    ext_d   = ext_q;
    head_d  = head_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (in_range) begin
      count_d = count_q + CntW'(1);
      if (count_q == '0) begin
        fhb_d = din;
      end else if (count_q == CntW'(1)) begin
        shb_d = din;
      end else if (count_q < CntW'(4)) begin
        seq_d = {seq_q[7:0], din};
      end else if (count_q < CntW'(8)) begin
        stamp_d = {stamp_q[23:0], din};
      end else if (count_q < CntW'(12)) begin
        ssrc_d = {ssrc_q[23:0], din};
      end
      // The first four payload bytes, wherever the payload starts.
      if (pos_x >= (PsW + 1)'(ps_q) && off[PsW:2] == '0) begin
        head_d = {head_q[23:0], din};
      end
      // Two bytes at the start of the extension header.
      if (fhb_q[4] && (pos_x == (PsW + 1)'(xo) || pos_x == (PsW + 1)'(xo) + 1'b1)) begin
        ext_d = {ext_q[7:0], din};
      end
    end else begin
      ovf_d = 1'b1;
    end
  end

  assign xo_d = 7'(rhp_pkg::FixedHdrBytes) + {1'b0, fhb_d[3:0], 2'b00};

  always_comb begin
    ps_d = PsW'(xo_d);
    if (fhb_d[4]) begin
      ps_d = PsW'(xo_d) + PsW'(4) + PsW'({ext_d, 2'b00});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      fhb_q   <= '0;
      shb_q   <= '0;
      seq_q   <= '0;
      stamp_q <= '0;
      ssrc_q  <= '0;
      ext_q   <= '0;
      ps_q    <= PsReset;
      head_q  <= '0;
    end else if (in_acc) begin
      if (in_data_i.last_byte) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        fhb_q   <= '0;
        shb_q   <= '0;
        seq_q   <= '0;
        stamp_q <= '0;
        ssrc_q  <= '0;
        ext_q   <= '0;
        ps_q    <= PsReset;
        head_q  <= '0;
      end else begin
        count_q <= count_d;
        ovf_q   <= ovf_d;
        fhb_q   <= fhb_d;
        shb_q   <= shb_d;
        seq_q   <= seq_d;
        stamp_q <= stamp_d;
        ssrc_q  <= ssrc_d;
        ext_q   <= ext_d;
        ps_q    <= ps_d;
        head_q  <= head_d;
      end
    end
  end

  // The header length is taken before this byte's capture: the last byte can
  // only move it when the packet already ends inside the fixed or extension header.
  always_comb begin
    snap_d.first_byte  = fhb_d;
    snap_d.second_byte = shb_d;
    snap_d.seq         = seq_d;
    snap_d.stamp       = stamp_d;
    snap_d.ssrc        = ssrc_d;
    snap_d.head        = head_d;
    snap_d.hdr         = ps_q;
    snap_d.hdr_pad     = (PsW + 1)'(ps_q) + (PsW + 1)'(fhb_d[5] ? din : 8'd0);
    snap_d.len         = rhp_pkg::LenW'(count_d);
    snap_d.ovf         = ovf_d;
  end

  assign o_load     = s_valid_q && (!o_valid_q || out_ready_i);
  assign in_ready_o = !s_valid_q || o_load;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.last_byte) begin
      snap_q <= snap_d;
    end
    if (o_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (in_acc && in_data_i.last_byte) begin
        s_valid_q <= 1'b1;
      end else if (o_load) begin
        s_valid_q <= 1'b0;
      end
      if (o_load) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Check stage: every length limit is a compare of the packet length
  // against a header end, so the checks run side by side.
  logic [PsW:0]     len_x;
  logic [PsW:0]     csrc_end;
  logic [PsW:0]     rest;
  rhp_pkg::status_e status;

  assign len_x    = (PsW + 1)'(snap_q.len);
  assign csrc_end = (PsW + 1)'(rhp_pkg::FixedHdrBytes) +
                    (PsW + 1)'({snap_q.first_byte[3:0], 2'b00});
  assign rest     = len_x - snap_q.hdr_pad;

  always_comb begin
    if (snap_q.ovf) begin
      status = rhp_pkg::ST_TOO_LONG;
    end else if (len_x < (PsW + 1)'(rhp_pkg::FixedHdrBytes)) begin
      status = rhp_pkg::ST_SHORT;
    end else if (snap_q.first_byte[7:6] != rhp_pkg::RtpVersion) begin
      status = rhp_pkg::ST_BAD_VER;
    end else if (len_x < csrc_end) begin
      status = rhp_pkg::ST_CSRC_OVR;
    end else if (snap_q.first_byte[4] && len_x < (PsW + 1)'(snap_q.hdr)) begin
      status = rhp_pkg::ST_EXT_OVR;
    end else if (snap_q.first_byte[5] && len_x < snap_q.hdr_pad) begin
      status = rhp_pkg::ST_PAD_OVR;
    end else begin
      status = rhp_pkg::ST_OK;
    end
  end

  always_comb begin
    res_d        = '0;
    res_d.status = status;
    if (status == rhp_pkg::ST_OK) begin
      res_d.marker         = snap_q.second_byte[7];
      res_d.payload_type   = snap_q.second_byte[6:0];
      res_d.sequence_res   = snap_q.seq;
      res_d.timestamp      = snap_q.stamp;
      res_d.source_id      = snap_q.ssrc;
      res_d.csrc_count     = snap_q.first_byte[3:0];
      res_d.has_extension  = snap_q.first_byte[4];
      res_d.has_padding    = snap_q.first_byte[5];
      res_d.header_length  = snap_q.hdr[11:0];
      res_d.payload_length = rest[11:0];
      res_d.ps_start       = (rest > (PsW + 1)'(4)) && (snap_q.head == rhp_pkg::PackStartCode);
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = res_q;

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.last_byte |=> count_q == '0 && ps_q == PsReset && !ovf_q)
    else $error("capture state not cleared after the last byte");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("byte count beyond the packet limit");

  a_last_to_snapshot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.last_byte |=> s_valid_q)
    else $error("last byte did not fill the snapshot");

  a_error_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && res_q.status != rhp_pkg::ST_OK |->
      res_q.header_length == '0 && res_q.payload_length == '0 &&
      res_q.source_id == '0 && !res_q.ps_start)
    else $error("error record carries nonzero fields");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q && o_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while both stages are full");
`endif

endmodule

@@ verif/tb_rtp_header_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header parser testbench
// Sends directed and random RTP packets one byte per item, with random stalls
// on both channels. A local parser predicts each packet's status record, and
// every record that leaves the block is compared with it field by field.
// ----------------------------------------------------------------------------
module tb_rtp_header_parser;

  localparam int unsigned RandomByteTarget = 800;
  localparam int          NumRows          = 24;

  typedef enum logic [1:0] {
    FILL_RAND,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  // One packet to send. The two bytes at the extension offset carry ext_words.
  // The pack start code goes at the payload start when ps is set. The final
  // byte carries pad when the padding flag is set. A typed row states its
  // error status directly, and all its other fields are zero.
  typedef struct packed {
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [15:0]      total;
    logic [15:0]      ext_words;
    logic [7:0]       pad;
    logic             ps;
    fill_e            fill;
    logic             typed;
    rhp_pkg::status_e typed_status;
  } pkt_spec_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  rhp_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  rhp_pkg::out_t out_data_o;

  // Packet parser state.
  int unsigned bytes_seen;
  logic [7:0]  first_q;
  logic [7:0]  second_q;
  logic [15:0] seq_q;
  logic [31:0] stamp_q;
  logic [31:0] ssrc_q;
  logic [15:0] ext_len_q;
  int unsigned pay_start_q;
  logic [31:0] pay_head_q;
  bit          overflow_q;

  rhp_pkg::out_t expected_records [$];
  int            mismatch_count = 0;
  int            status_seen [8] = '{default: 0};
  int unsigned   packets_sent = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   sender_idle_pct = 0;
  int unsigned   recv_idle_pct = 20;
  int unsigned   recv_stall_left = 0;
  bit            steady_phase = 1'b0;

  pkt_spec_t directed_rows [NumRows] = '{
    // Short packets. A short packet with a bad version still reports short.
    '{8'h80, 8'h00, 16'd1,    16'd0,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_SHORT},
    '{8'h80, 8'h00, 16'd11,   16'd0,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_SHORT},
    '{8'h00, 8'h00, 16'd5,    16'd0,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_SHORT},
    // Minimal headers with all ones and all zeros in the fixed fields, then bad versions.
    '{8'h80, 8'hFF, 16'd12,   16'd0,   8'd0, 1'b0, FILL_ONES, 1'b0, rhp_pkg::ST_OK},
    '{8'h80, 8'h00, 16'd12,   16'd0,   8'd0, 1'b0, FILL_ZERO, 1'b0, rhp_pkg::ST_OK},
    '{8'h00, 8'h00, 16'd12,   16'd0,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_BAD_VER},
    '{8'h40, 8'h00, 16'd30,   16'd0,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_BAD_VER},
    '{8'hFF, 8'hFF, 16'd100,  16'd0,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_BAD_VER},
    // A full CSRC list that fits exactly, and then one byte too few.
    '{8'h8F, 8'h5A, 16'd72,   16'd0,   8'd0, 1'b0, FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    '{8'h8F, 8'h00, 16'd71,   16'd0,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_CSRC_OVR},
    '{8'hBF, 8'h00, 16'd40,   16'd0,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_CSRC_OVR},
    // Extension header: empty, cut inside its first word, and cut inside its body.
    '{8'h90, 8'h00, 16'd16,   16'd0,   8'd0, 1'b0, FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    '{8'h90, 8'h00, 16'd15,   16'd0,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_EXT_OVR},
    '{8'h90, 8'h00, 16'd20,   16'd3,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_EXT_OVR},
    '{8'hB0, 8'h00, 16'd14,   16'd0,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_EXT_OVR},
    // Padding larger than the payload, exactly the payload, and zero.
    '{8'hA0, 8'h00, 16'd12,   16'd0,   8'd1, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_PAD_OVR},
    '{8'hA0, 8'h00, 16'd20,   16'd0,   8'd8, 1'b0, FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    '{8'hA0, 8'h00, 16'd20,   16'd0,   8'd0, 1'b0, FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    // The pack start code needs more than four payload bytes.
    '{8'h80, 8'h00, 16'd16,   16'd0,   8'd0, 1'b1, FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    '{8'h80, 8'h00, 16'd17,   16'd0,   8'd0, 1'b1, FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    '{8'hB3, 8'h81, 16'd50,   16'd2,   8'd4, 1'b1, FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    // A full CSRC list and an empty extension header that fill the packet completely.
    '{8'h9F, 8'h7F, 16'd76,   16'd0,   8'd0, 1'b0, FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    // One byte over the limit; too long takes priority over a bad version.
    // The next packet starts clean.
    '{8'h00, 8'h00, 16'd2049, 16'd0,   8'd0, 1'b0, FILL_RAND, 1'b1, rhp_pkg::ST_TOO_LONG},
    '{8'hB1, 8'h7F, 16'd40,   16'd1,   8'd3, 1'b1, FILL_RAND, 1'b0, rhp_pkg::ST_OK}
  };

  rtp_header_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_parser();
    bytes_seen  = 0;
    first_q     = '0;
    second_q    = '0;
    seq_q       = '0;
    stamp_q     = '0;
    ssrc_q      = '0;
    ext_len_q   = '0;
    pay_start_q = rhp_pkg::FixedHdrBytes;
    pay_head_q  = '0;
    overflow_q  = 1'b0;
  endfunction

  // Advances the parser by one accepted byte. On the last byte it returns
  // the status record of the packet and starts over.
  function automatic void parse_byte(input logic [7:0] b, input logic last,
                                     output bit done, output rhp_pkg::out_t rec);
    int unsigned      pos;
    int unsigned      xo;
    int unsigned      hdr;
    int unsigned      rest;
    int unsigned      xlen;
    rhp_pkg::status_e st;
    pos  = bytes_seen;
    done = 1'b0;
    rec  = '0;
    if (pos < rhp_pkg::MaxPacketBytes) begin
      if (pos == 0) first_q = b;
      else if (pos == 1) second_q = b;
      else if (pos < 4) seq_q = {seq_q[7:0], b};
      else if (pos < 8) stamp_q = {stamp_q[23:0], b};
      else if (pos < 12) ssrc_q = {ssrc_q[23:0], b};
      if (pos >= pay_start_q && pos < pay_start_q + 4) pay_head_q = {pay_head_q[23:0], b};
      xo = rhp_pkg::FixedHdrBytes + 4 * first_q[3:0];
      // The extension length is taken from the first two bytes of the extension header.
      if (first_q[4] && pos >= rhp_pkg::FixedHdrBytes && (pos == xo || pos == xo + 1)) begin
        ext_len_q = {ext_len_q[7:0], b};
      end
      pay_start_q = xo;
      if (first_q[4]) pay_start_q = xo + 4 + 4 * ext_len_q;
      bytes_seen = pos + 1;
    end else begin
      overflow_q = 1'b1;
    end
    if (!last) return;

    hdr  = rhp_pkg::FixedHdrBytes;
    rest = 0;
    st   = rhp_pkg::ST_OK;
    if (overflow_q) st = rhp_pkg::ST_TOO_LONG;
    else if (bytes_seen < rhp_pkg::FixedHdrBytes) st = rhp_pkg::ST_SHORT;
    else if (first_q[7:6] != rhp_pkg::RtpVersion) st = rhp_pkg::ST_BAD_VER;
    else begin
      rest = bytes_seen - rhp_pkg::FixedHdrBytes;
      if (4 * first_q[3:0] > rest) st = rhp_pkg::ST_CSRC_OVR;
      else begin
        hdr  = hdr + 4 * first_q[3:0];
        rest = rest - 4 * first_q[3:0];
        if (first_q[4]) begin
          xlen = 4 + 4 * ext_len_q;
          if (rest < xlen) st = rhp_pkg::ST_EXT_OVR;
          else begin
            hdr  = hdr + xlen;
            rest = rest - xlen;
          end
        end
        // The final byte of the packet is the padding count.
        if (st == rhp_pkg::ST_OK && first_q[5]) begin
          if (rest < b) st = rhp_pkg::ST_PAD_OVR;
          else rest = rest - b;
        end
      end
    end

    rec.status = st;
    if (st == rhp_pkg::ST_OK) begin
      rec.marker         = second_q[7];
      rec.payload_type   = second_q[6:0];
      rec.sequence_res   = seq_q;
      rec.timestamp      = stamp_q;
      rec.source_id      = ssrc_q;
      rec.csrc_count     = first_q[3:0];
      rec.has_extension  = first_q[4];
      rec.has_padding    = first_q[5];
      rec.header_length  = 12'(hdr);
      rec.payload_length = 12'(rest);
      rec.ps_start       = rest > 4 && pay_head_q == rhp_pkg::PackStartCode;
    end
    done = 1'b1;
    clear_parser();
  endfunction

  // Builds the packet bytes from a spec and drives them one item at a time.
  // This task is entered and left at a falling edge.
  task automatic send_packet(input pkt_spec_t spec);
    logic [7:0]    pkt [$];
    int unsigned   xo;
    int unsigned   pstart;
    rhp_pkg::out_t rec;
    bit            done;
    pkt = {};
    for (int unsigned i = 0; i < spec.total; i++) begin
      case (spec.fill)
        FILL_ZERO: pkt.push_back(8'h00);
        FILL_ONES: pkt.push_back(8'hFF);
        default:   pkt.push_back(8'($urandom));
      endcase
    end
    xo     = rhp_pkg::FixedHdrBytes + 4 * spec.b0[3:0];
    pstart = xo;
    if (spec.b0[4]) begin
      if (xo + 1 < spec.total) begin
        pkt[xo]     = spec.ext_words[15:8];
        pkt[xo + 1] = spec.ext_words[7:0];
      end
      pstart = xo + 4 + 4 * spec.ext_words;
    end
    if (spec.ps) begin
      for (int unsigned k = 0; k < 4; k++) begin
        if (pstart + k < spec.total) begin
          pkt[pstart + k] = 8'(rhp_pkg::PackStartCode >> (24 - 8 * k));
        end
      end
    end
    if (spec.b0[5]) pkt[spec.total - 1] = spec.pad;
    pkt[0] = spec.b0;
    if (spec.total > 1) pkt[1] = spec.b1;

    if (steady_phase || $urandom_range(0, 2) == 0) sender_idle_pct = 0;
    else sender_idle_pct = $urandom_range(3, 30);

    foreach (pkt[i]) begin
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= '{data_byte: pkt[i], last_byte: (i == pkt.size() - 1)};
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      parse_byte(pkt[i], i == pkt.size() - 1, done, rec);
      if (done) begin
        if (spec.typed) begin
          rec        = '0;
          rec.status = spec.typed_status;
        end
        expected_records.push_back(rec);
      end
      @(negedge clk_i);
    end
    packets_sent++;
    bytes_sent += pkt.size();
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver: ready drops in random bursts, and the burst rate changes now and then.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 299) == 0) begin
      recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 40);
    end
    if (!steady_phase && recv_stall_left == 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_stall_left = $urandom_range(1, 18);
    end
    if (recv_stall_left != 0) begin
      out_ready_i <= 1'b0;
      recv_stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rhp_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      status_seen[out_data_o.status]++;
      if (expected_records.size() == 0) begin
        $display("%0t: status record with none expected: expected nothing, got %h",
                 $time, out_data_o);
        mismatch_count++;
      end else begin
        want = expected_records.pop_front();
        check_field("status", want.status, out_data_o.status);
        check_field("marker", want.marker, out_data_o.marker);
        check_field("payload_type", want.payload_type, out_data_o.payload_type);
        check_field("sequence_res", want.sequence_res, out_data_o.sequence_res);
        check_field("timestamp", want.timestamp, out_data_o.timestamp);
        check_field("source_id", want.source_id, out_data_o.source_id);
        check_field("csrc_count", want.csrc_count, out_data_o.csrc_count);
        check_field("has_extension", want.has_extension, out_data_o.has_extension);
        check_field("has_padding", want.has_padding, out_data_o.has_padding);
        check_field("header_length", want.header_length, out_data_o.header_length);
        check_field("payload_length", want.payload_length, out_data_o.payload_length);
        check_field("ps_start", want.ps_start, out_data_o.ps_start);
      end
    end
  end

  initial begin
    pkt_spec_t   spec;
    logic [31:0] r;
    int unsigned kind;
    int unsigned hdr_len;
    int unsigned pay_len;
    int unsigned pad_len;
    int unsigned directed_bytes;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    clear_parser();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) send_packet(directed_rows[i]);
    directed_bytes = bytes_sent;

    // Hold the sender until every record of the directed packets has come back.
    in_valid_i <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    @(negedge clk_i);

    // Most random packets are well formed with random content. The rest are
    // truncated packets or bytes that are pure noise.
    while (bytes_sent - directed_bytes < RandomByteTarget) begin
      if (bytes_sent - directed_bytes > RandomByteTarget * 4 / 5) steady_phase = 1'b1;
      r                 = $urandom;
      kind              = $urandom_range(0, 99);
      spec              = '0;
      spec.fill         = FILL_RAND;
      spec.typed_status = rhp_pkg::ST_OK;
      spec.b1           = r[15:8];
      spec.b0           = {rhp_pkg::RtpVersion, r[5:0]};
      if ($urandom_range(0, 3) != 0) spec.b0[3:0] = 4'($urandom_range(0, 2));
      spec.ext_words = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 40))
                                                   : 16'($urandom_range(0, 3));
      pay_len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 20);
      pad_len = 0;
      if (spec.b0[5]) begin
        pad_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
      end
      spec.pad = 8'(pad_len);
      spec.ps  = r[16];
      hdr_len  = rhp_pkg::FixedHdrBytes + 4 * spec.b0[3:0];
      if (spec.b0[4]) hdr_len = hdr_len + 4 + 4 * spec.ext_words;
      spec.total = 16'(hdr_len + pay_len + pad_len);
      if (kind >= 85) begin
        spec.b0        = r[31:24];
        spec.ext_words = 16'($urandom);
        spec.pad       = 8'($urandom);
        spec.total     = 16'($urandom_range(1, 40));
      end else if (kind >= 70) begin
        spec.total = 16'($urandom_range(1, spec.total + 3));
      end
      send_packet(spec);
    end
    in_valid_i <= 1'b0;

    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d packets in %0d bytes, directed edge cases first, then random.",
             packets_sent, bytes_sent);
    $display("Records: ok %0d, short %0d, bad version %0d, csrc %0d, ext %0d, pad %0d, long %0d",
             status_seen[rhp_pkg::ST_OK], status_seen[rhp_pkg::ST_SHORT],
             status_seen[rhp_pkg::ST_BAD_VER], status_seen[rhp_pkg::ST_CSRC_OVR],
             status_seen[rhp_pkg::ST_EXT_OVR], status_seen[rhp_pkg::ST_PAD_OVR],
             status_seen[rhp_pkg::ST_TOO_LONG]);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d records still expected", expected_records.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rhp_pkg.sv
sv/rtp_header_parser.sv
verif/tb_rtp_header_parser.sv
